FILE: sv/block_matrix_multiply_accumulate_defines.svh
// assertion macros for the checker module bmma_chk
`ifndef BLOCK_MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH
`define BLOCK_MATRIX_MULTIPLY_ACCUMULATE_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define BMMA_CHECK(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// clocked check that also holds during reset
`define BMMA_CHECK_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: sv/bmma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmma_pkg;

  // default matrix dimension
  localparam int BMMA_MAX_DIM_DEF = 8;

  // field widths
  localparam int CMD_W      = 2;
  localparam int IDX_W      = 3;
  localparam int VAL_W      = 40;
  localparam int OPD_W      = 16;
  localparam int PROD_W     = 32;
  localparam int KDIM_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // input commands
  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_C = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COMMON_DIM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LAST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_FIRST  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_LAST   = 3'd4;

  // configuration reset values
  localparam logic [KDIM_W-1:0] RST_COMMON_DIM = 4'd8;
  localparam logic [IDX_W-1:0]  RST_ROW_FIRST  = 3'd0;
  localparam logic [IDX_W-1:0]  RST_ROW_LAST   = 3'd7;
  localparam logic [IDX_W-1:0]  RST_COL_FIRST  = 3'd0;
  localparam logic [IDX_W-1:0]  RST_COL_LAST   = 3'd7;

  typedef logic signed [OPD_W-1:0]  opd_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [VAL_W-1:0]  acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [KDIM_W-1:0] common_dim;
    logic [IDX_W-1:0]  row_first;
    logic [IDX_W-1:0]  row_last;
    logic [IDX_W-1:0]  col_first;
    logic [IDX_W-1:0]  col_last;
  } cfg_t;

  // operand memory half-word write enables
  typedef struct packed {
    logic we_a;
    logic we_b;
  } op_wr_t;

  // multiply-accumulate pipeline controls
  typedef struct packed {
    logic load_c;
    logic mul_en;
  } mac_ctl_t;

  // accumulate with saturation to the signed accumulator range
  function automatic acc_t sat_add(acc_t acc, prod_t p);
    logic signed [VAL_W:0] sum;
    sum = {acc[VAL_W-1], acc} + {{(VAL_W+1-PROD_W){p[PROD_W-1]}}, p};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      sat_add = sum[VAL_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = sum[VAL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/bmma_if.sv
`timescale 1ns / 1ps
`default_nettype none

// element and command channel
interface bmma_in_if import bmma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [IDX_W-1:0]        row;
  logic [IDX_W-1:0]        col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output command, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input command, input row, input col, input value,
                  output ready);
endinterface

// result channel
interface bmma_out_if import bmma_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output last, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input last, output ready);
endinterface

`default_nettype wire

FILE: sv/bmma_opmem.sv
`timescale 1ns / 1ps
`default_nettype none

module bmma_opmem import bmma_pkg::*; #(
  parameter int  MAX_DIM = BMMA_MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int AW      = $clog2(DEPTH)
) (
  input  logic          clk,
  input  op_wr_t        wr,
  input  logic [AW-1:0] waddr,
  input  opd_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output opd_t          a_q,
  output opd_t          b_q
);

  // low half holds A, high half holds B
  logic [1:0][OPD_W-1:0] mem [DEPTH];

  // one write port with half-word enables
  always_ff @(posedge clk) begin
    if (wr.we_a) begin
      mem[waddr][0] <= wdata;
    end
    if (wr.we_b) begin
      mem[waddr][1] <= wdata;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      a_q <= mem[raddr_a][0];
      b_q <= mem[raddr_b][1];
    end
  end

endmodule

`default_nettype wire

FILE: sv/bmma_accmem.sv
`timescale 1ns / 1ps
`default_nettype none

module bmma_accmem import bmma_pkg::*; #(
  parameter int  MAX_DIM = BMMA_MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int AW      = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  acc_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output acc_t          c_q
);

  acc_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      c_q <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/bmma_mac.sv
`timescale 1ns / 1ps
`default_nettype none

module bmma_mac import bmma_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  opd_t     a_q,
  input  opd_t     b_q,
  input  acc_t     c_q,
  output acc_t     acc,
  output logic     busy
);

  prod_t prod_r;
  logic  prod_v_r;
  acc_t  acc_r;

  // product stage, valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.mul_en;
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= prod_t'(a_q) * prod_t'(b_q);
    end
  end

  // accumulator: seeded from the stored element, then saturating adds
  always_ff @(posedge clk) begin
    if (ctl.load_c) begin
      acc_r <= c_q;
    end else if (prod_v_r) begin
      acc_r <= sat_add(acc_r, prod_r);
    end
  end

  assign acc  = acc_r;
  assign busy = prod_v_r;

endmodule

`default_nettype wire

FILE: sv/bmma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bmma_ctrl import bmma_pkg::*; #(
  parameter int  MAX_DIM = BMMA_MAX_DIM_DEF,
  localparam int DEPTH   = MAX_DIM * MAX_DIM,
  localparam int AW      = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  bmma_in_if.sink           in_ch,
  bmma_out_if.source        out_ch,
  output op_wr_t            op_wr,
  output logic [AW-1:0]     op_waddr,
  output opd_t              op_wdata,
  output logic              op_re,
  output logic [AW-1:0]     op_raddr_a,
  output logic [AW-1:0]     op_raddr_b,
  output logic              acc_we,
  output logic [AW-1:0]     acc_waddr,
  output acc_t              acc_wdata,
  output logic              acc_re,
  output logic [AW-1:0]     acc_raddr,
  output mac_ctl_t          mac_ctl,
  input  acc_t              mac_acc,
  input  logic              mac_busy
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // largest usable row or column index
  localparam logic [IDX_W-1:0] IDX_CAP = (MAX_DIM >= 2**IDX_W) ?
                                         IDX_W'(2**IDX_W - 1) : IDX_W'(MAX_DIM - 1);
  // largest usable term count
  localparam logic [KDIM_W-1:0] KDIM_CAP = (MAX_DIM >= 2**KDIM_W - 1) ?
                                           KDIM_W'(2**KDIM_W - 1) : KDIM_W'(MAX_DIM);
  localparam logic [AW-1:0] DIM_A     = AW'(MAX_DIM);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] addr_of(logic [AW-1:0] r, logic [AW-1:0] c);
    addr_of = r * DIM_A + c;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [IDX_W-1:0]  r_r, r_nxt;
  logic [IDX_W-1:0]  c_r, c_nxt;
  logic [IDX_W-1:0]  c_first_r, c_first_nxt;
  logic [IDX_W-1:0]  r_hi_r, r_hi_nxt;
  logic [IDX_W-1:0]  c_hi_r, c_hi_nxt;
  logic [KDIM_W-1:0] kdim_r, kdim_nxt;
  logic [KDIM_W-1:0] k_r, k_nxt;
  logic              ab_v_r, c_v_r;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  acc_t              out_value_r;
  logic              out_last_r;

  logic              in_acc, idx_ok, blk_empty, start_blk, issue, emit_go, is_last;
  logic [IDX_W-1:0]  r_hi, c_hi;
  logic [KDIM_W-1:0] kdim, k_inc;
  logic [AW-1:0]     in_addr, cur_addr;

  // input transfer and write decode
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign idx_ok      = (in_ch.row <= IDX_CAP) && (in_ch.col <= IDX_CAP);
  assign in_addr     = addr_of(AW'(in_ch.row), AW'(in_ch.col));

  assign op_wr.we_a = in_acc && (in_ch.command == CMD_WRITE_A) && idx_ok;
  assign op_wr.we_b = in_acc && (in_ch.command == CMD_WRITE_B) && idx_ok;
  assign op_waddr   = in_addr;
  assign op_wdata   = in_ch.value[OPD_W-1:0];

  // block bounds from the registers, clipped to the array
  assign r_hi      = (cfg.row_last > IDX_CAP) ? IDX_CAP : cfg.row_last;
  assign c_hi      = (cfg.col_last > IDX_CAP) ? IDX_CAP : cfg.col_last;
  assign kdim      = (int'(cfg.common_dim) > MAX_DIM) ? KDIM_CAP : cfg.common_dim;
  assign blk_empty = (cfg.row_first > cfg.row_last) || (cfg.col_first > cfg.col_last) ||
                     (cfg.row_first > IDX_CAP) || (cfg.col_first > IDX_CAP);
  assign start_blk = in_acc && (in_ch.command == CMD_COMPUTE) && !blk_empty;

  // operand reads, one term per cycle
  assign issue      = ((state_r == S_START) && (kdim_r != '0)) || (state_r == S_MAC);
  assign k_inc      = k_r + 1'b1;
  assign op_re      = issue;
  assign op_raddr_a = addr_of(AW'(r_r), AW'(k_r));
  assign op_raddr_b = addr_of(AW'(k_r), AW'(c_r));

  // element finish
  assign cur_addr = addr_of(AW'(r_r), AW'(c_r));
  assign emit_go  = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign is_last  = (r_r == r_hi_r) && (c_r == c_hi_r);

  // accumulator memory: clear pass, direct load, or write-back of the sum
  assign acc_re    = (state_r == S_START);
  assign acc_raddr = cur_addr;
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = cur_addr;
    acc_wdata = mac_acc;
    if (state_r == S_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_addr_r;
      acc_wdata = '0;
    end else if (in_acc && (in_ch.command == CMD_WRITE_C) && idx_ok) begin
      acc_we    = 1'b1;
      acc_waddr = in_addr;
      acc_wdata = in_ch.value;
    end else if (emit_go) begin
      acc_we = 1'b1;
    end
  end

  assign mac_ctl.load_c = c_v_r;
  assign mac_ctl.mul_en = ab_v_r;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    c_first_nxt  = c_first_r;
    r_hi_nxt     = r_hi_r;
    c_hi_nxt     = c_hi_r;
    kdim_nxt     = kdim_r;
    k_nxt        = k_r;
    case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_blk) begin
          r_nxt       = cfg.row_first;
          c_nxt       = cfg.col_first;
          c_first_nxt = cfg.col_first;
          r_hi_nxt    = r_hi;
          c_hi_nxt    = c_hi;
          kdim_nxt    = kdim;
          k_nxt       = '0;
          state_nxt   = S_START;
        end
      end
      S_START, S_MAC: begin
        if (issue) begin
          k_nxt = k_inc;
        end
        state_nxt = (!issue || (k_inc == kdim_r)) ? S_WAIT : S_MAC;
      end
      S_WAIT: begin
        if (!ab_v_r && !c_v_r && !mac_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = '0;
            state_nxt = S_START;
            if (c_r == c_hi_r) begin
              c_nxt = c_first_r;
              r_nxt = r_r + 1'b1;
            end else begin
              c_nxt = c_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      r_r         <= '0;
      c_r         <= '0;
      c_first_r   <= '0;
      r_hi_r      <= '0;
      c_hi_r      <= '0;
      kdim_r      <= '0;
      k_r         <= '0;
      ab_v_r      <= 1'b0;
      c_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      c_first_r   <= c_first_nxt;
      r_hi_r      <= r_hi_nxt;
      c_hi_r      <= c_hi_nxt;
      kdim_r      <= kdim_nxt;
      k_r         <= k_nxt;
      ab_v_r      <= issue;
      c_v_r       <= acc_re;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_row_r   <= r_r;
      out_col_r   <= c_r;
      out_value_r <= mac_acc;
      out_last_r  <= is_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.last      = out_last_r;

endmodule

`default_nettype wire

FILE: sv/block_matrix_multiply_accumulate.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake       payload
// in_ch     in    valid/ready     command, row, col, value
// out_ch    out   valid/ready     out_row, out_col, out_value, last
// cfg_*     in    cfg_we only     cfg_idx, cfg_data
//
// write commands are taken one per cycle while in_ch.ready is high and produce no result
// compute: after the transfer, each block element (common_dim clipped to MAX_DIM) takes
//   one term per cycle, the first also reading the accumulator, then the pipeline drain
//   and a write-back; with no terms only the accumulator read, drain and write-back remain
// after reset a clearing pass zeroes the MAX_DIM*MAX_DIM accumulators one by one;
//   in_ch.ready stays low meanwhile
// a result held on out_ch stalls the next element in its write-back cycle

module block_matrix_multiply_accumulate import bmma_pkg::*; #(
  parameter int MAX_DIM = BMMA_MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bmma_in_if.sink               in_ch,
  bmma_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  cfg_t          cfg_r;
  op_wr_t        op_wr;
  logic [AW-1:0] op_waddr, op_raddr_a, op_raddr_b;
  opd_t          op_wdata, a_q, b_q;
  logic          op_re;
  logic          acc_we, acc_re;
  logic [AW-1:0] acc_waddr, acc_raddr;
  acc_t          acc_wdata, c_q, mac_acc;
  mac_ctl_t      mac_ctl;
  logic          mac_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.common_dim <= RST_COMMON_DIM;
      cfg_r.row_first  <= RST_ROW_FIRST;
      cfg_r.row_last   <= RST_ROW_LAST;
      cfg_r.col_first  <= RST_COL_FIRST;
      cfg_r.col_last   <= RST_COL_LAST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_COMMON_DIM: cfg_r.common_dim <= cfg_data;
        CFG_ROW_FIRST:  cfg_r.row_first  <= cfg_data[IDX_W-1:0];
        CFG_ROW_LAST:   cfg_r.row_last   <= cfg_data[IDX_W-1:0];
        CFG_COL_FIRST:  cfg_r.col_first  <= cfg_data[IDX_W-1:0];
        CFG_COL_LAST:   cfg_r.col_last   <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and result register
  bmma_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .op_wr      (op_wr),
    .op_waddr   (op_waddr),
    .op_wdata   (op_wdata),
    .op_re      (op_re),
    .op_raddr_a (op_raddr_a),
    .op_raddr_b (op_raddr_b),
    .acc_we     (acc_we),
    .acc_waddr  (acc_waddr),
    .acc_wdata  (acc_wdata),
    .acc_re     (acc_re),
    .acc_raddr  (acc_raddr),
    .mac_ctl    (mac_ctl),
    .mac_acc    (mac_acc),
    .mac_busy   (mac_busy)
  );

  // operand matrices A and B
  bmma_opmem #(.MAX_DIM(MAX_DIM)) u_opmem (
    .clk     (clk),
    .wr      (op_wr),
    .waddr   (op_waddr),
    .wdata   (op_wdata),
    .re      (op_re),
    .raddr_a (op_raddr_a),
    .raddr_b (op_raddr_b),
    .a_q     (a_q),
    .b_q     (b_q)
  );

  // accumulator matrix C
  bmma_accmem #(.MAX_DIM(MAX_DIM)) u_accmem (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .c_q   (c_q)
  );

  // multiplier and saturating accumulator
  bmma_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a_q   (a_q),
    .b_q   (b_q),
    .c_q   (c_q),
    .acc   (mac_acc),
    .busy  (mac_busy)
  );

endmodule

`default_nettype wire

FILE: sv/bmma_chk.sv
`timescale 1ns / 1ps
`default_nettype none

`include "block_matrix_multiply_accumulate_defines.svh"

module bmma_chk import bmma_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_row,
  input logic [IDX_W-1:0] out_col,
  input acc_t             out_value,
  input logic             out_last
);

  // a stalled result stays offered
  `BMMA_CHECK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // a stalled result keeps its payload
  `BMMA_CHECK(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_value) && $stable(out_row) && $stable(out_col) && $stable(out_last), "result changed while stalled")

  // no new item is taken in the middle of a block
  `BMMA_CHECK(a_busy_mid_block, clk, rst_n, out_valid && !out_last |-> !in_ready, "input ready inside a block")

  // reset leaves the block busy clearing and with nothing offered
  `BMMA_CHECK_ALWAYS(a_reset_quiet, clk, !rst_n |=> !in_ready && !out_valid, "activity right after reset")

endmodule

bind block_matrix_multiply_accumulate bmma_chk u_bmma_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_row   (out_ch.out_row),
  .out_col   (out_ch.out_col),
  .out_value (out_ch.out_value),
  .out_last  (out_ch.last)
);

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bmma_pkg::*;

  localparam int DIM         = BMMA_MAX_DIM_DEF;
  localparam int ITEM_TARGET = 370;
  localparam int IDLE_CYCLES = 24;
  localparam int PRINT_LIMIT = 40;
  localparam int PLAN_LEN    = 37;

  // index past the last register, writes to it change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;

  // commands widened to the shared code field of a plan row
  localparam logic [CFG_IDX_W-1:0] OP_WRITE_A = CFG_IDX_W'(CMD_WRITE_A);
  localparam logic [CFG_IDX_W-1:0] OP_WRITE_B = CFG_IDX_W'(CMD_WRITE_B);
  localparam logic [CFG_IDX_W-1:0] OP_WRITE_C = CFG_IDX_W'(CMD_WRITE_C);
  localparam logic [CFG_IDX_W-1:0] OP_COMPUTE = CFG_IDX_W'(CMD_COMPUTE);

  typedef enum logic {ROW_ITEM, ROW_REG} plan_kind_t;

  // one directed step: an element or command transfer, or a register write
  typedef struct packed {
    plan_kind_t           kind;
    logic [CFG_IDX_W-1:0] code;   // command, or register index
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic [VAL_W-1:0]     value;  // element value, or register data
    logic                 typed;  // want holds the result value of every element
    logic [VAL_W-1:0]     want;
  } plan_row_t;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    acc_t             value;
    logic             last;
  } elem_t;

  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // no terms summed: the whole 8x8 block streams out as zeros after reset
    '{ROW_REG,  CFG_COMMON_DIM, 3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b1, 40'd0},
    // single element block at the origin, one term
    '{ROW_REG,  CFG_COMMON_DIM, 3'd0, 3'd0, 40'd1,            1'b0, 40'd0},
    '{ROW_REG,  CFG_ROW_LAST,   3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    '{ROW_REG,  CFG_COL_LAST,   3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    '{ROW_ITEM, OP_WRITE_A,     3'd0, 3'd0, 40'hFF_FFFF_7FFF, 1'b0, 40'd0},
    '{ROW_ITEM, OP_WRITE_B,     3'd0, 3'd0, 40'h00_0000_7FFF, 1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b1, 40'h00_3FFF_0001},
    // most negative operands, positive product
    '{ROW_ITEM, OP_WRITE_A,     3'd0, 3'd0, 40'h00_0000_8000, 1'b0, 40'd0},
    '{ROW_ITEM, OP_WRITE_B,     3'd0, 3'd0, 40'hFF_FFFF_8000, 1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    // saturation at the top
    '{ROW_ITEM, OP_WRITE_C,     3'd0, 3'd0, ACC_MAX,          1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b1, ACC_MAX},
    // saturation at the bottom
    '{ROW_ITEM, OP_WRITE_B,     3'd0, 3'd0, 40'h00_0000_7FFF, 1'b0, 40'd0},
    '{ROW_ITEM, OP_WRITE_C,     3'd0, 3'd0, ACC_MIN,          1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b1, ACC_MIN},
    // far corner, column bound with the spare data bit set
    '{ROW_REG,  CFG_ROW_FIRST,  3'd0, 3'd0, 40'd7,            1'b0, 40'd0},
    '{ROW_REG,  CFG_ROW_LAST,   3'd0, 3'd0, 40'd7,            1'b0, 40'd0},
    '{ROW_REG,  CFG_COL_FIRST,  3'd0, 3'd0, 40'd7,            1'b0, 40'd0},
    '{ROW_REG,  CFG_COL_LAST,   3'd0, 3'd0, 40'd15,           1'b0, 40'd0},
    '{ROW_ITEM, OP_WRITE_A,     3'd7, 3'd0, 40'h00_0000_0100, 1'b0, 40'd0},
    '{ROW_ITEM, OP_WRITE_B,     3'd0, 3'd7, 40'h00_0000_FFFF, 1'b0, 40'd0},
    '{ROW_ITEM, OP_WRITE_C,     3'd7, 3'd7, 40'd0,            1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b1, 40'hFF_FFFF_FF00},
    // empty block, rows reversed
    '{ROW_REG,  CFG_ROW_FIRST,  3'd0, 3'd0, 40'd5,            1'b0, 40'd0},
    '{ROW_REG,  CFG_ROW_LAST,   3'd0, 3'd0, 40'd2,            1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    // empty block, columns reversed
    '{ROW_REG,  CFG_ROW_FIRST,  3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    '{ROW_REG,  CFG_ROW_LAST,   3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    '{ROW_REG,  CFG_COL_FIRST,  3'd0, 3'd0, 40'd6,            1'b0, 40'd0},
    '{ROW_REG,  CFG_COL_LAST,   3'd0, 3'd0, 40'd3,            1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    // unused index, then common dimension above the matrix size
    '{ROW_REG,  CFG_UNUSED,     3'd0, 3'd0, 40'd15,           1'b0, 40'd0},
    '{ROW_REG,  CFG_COMMON_DIM, 3'd0, 3'd0, 40'd15,           1'b0, 40'd0},
    '{ROW_REG,  CFG_COL_FIRST,  3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    '{ROW_REG,  CFG_COL_LAST,   3'd0, 3'd0, 40'd0,            1'b0, 40'd0},
    '{ROW_ITEM, OP_COMPUTE,     3'd0, 3'd0, 40'd0,            1'b0, 40'd0}
  };

  logic                  clk      = 1'b0;
  logic                  rst_n    = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bmma_in_if  in_ch ();
  bmma_out_if out_ch ();

  block_matrix_multiply_accumulate dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow copy of the matrices and bound registers
  opd_t  mat_a [DIM*DIM];
  opd_t  mat_b [DIM*DIM];
  acc_t  mat_c [DIM*DIM];
  bit    a_loaded [DIM*DIM];
  bit    b_loaded [DIM*DIM];
  cfg_t  block_cfg;
  elem_t expected_elems [$];

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold   = 0;

  int errors         = 0;
  int items_in       = 0;
  int directed_items = 0;
  int computes       = 0;
  int empty_computes = 0;
  int reg_writes     = 0;
  int results_seen   = 0;
  int saturated      = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("tb_top: mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic bit block_empty();
    return (block_cfg.row_first > block_cfg.row_last) ||
           (block_cfg.col_first > block_cfg.col_last);
  endfunction

  function automatic int eff_terms();
    return (block_cfg.common_dim > DIM) ? DIM : int'(block_cfg.common_dim);
  endfunction

  // multiply-accumulate over the block, one expected element per position
  function automatic void predict_block();
    longint sum;
    elem_t  e;
    int     kd;
    int     rl;
    int     cl;
    if (block_empty()) begin
      empty_computes++;
      return;
    end
    kd = eff_terms();
    rl = block_cfg.row_last;
    cl = block_cfg.col_last;
    for (int r = block_cfg.row_first; r <= rl; r++) begin
      for (int c = block_cfg.col_first; c <= cl; c++) begin
        sum = mat_c[r*DIM+c];
        for (int k = 0; k < kd; k++) begin
          sum += longint'(mat_a[r*DIM+k]) * longint'(mat_b[k*DIM+c]);
          if (sum > longint'(ACC_MAX)) begin
            sum = ACC_MAX;
          end else if (sum < longint'(ACC_MIN)) begin
            sum = ACC_MIN;
          end
        end
        mat_c[r*DIM+c] = acc_t'(sum);
        e.row   = IDX_W'(r);
        e.col   = IDX_W'(c);
        e.value = acc_t'(sum);
        e.last  = (r == rl) && (c == cl);
        if (e.value == ACC_MAX || e.value == ACC_MIN) begin
          saturated++;
        end
        expected_elems = {expected_elems, e};
      end
    end
  endfunction

  function automatic void predict_transfer(input logic [CMD_W-1:0] cmd,
                                           input logic [IDX_W-1:0] row,
                                           input logic [IDX_W-1:0] col,
                                           input logic [VAL_W-1:0] value);
    int idx;
    idx = row * DIM + col;
    case (cmd)
      CMD_WRITE_A: begin
        mat_a[idx]    = value[OPD_W-1:0];
        a_loaded[idx] = 1'b1;
      end
      CMD_WRITE_B: begin
        mat_b[idx]    = value[OPD_W-1:0];
        b_loaded[idx] = 1'b1;
      end
      CMD_WRITE_C: mat_c[idx] = value;
      CMD_COMPUTE: begin
        computes++;
        predict_block();
      end
      default: ;
    endcase
  endfunction

  // element values: half full random, the rest near the accumulator and operand limits
  function automatic logic [VAL_W-1:0] draw_value();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0:       return ACC_MAX - acc_t'(w[7:0]);
      1:       return ACC_MIN + acc_t'(w[7:0]);
      2:       return {w[VAL_W-1:OPD_W], 16'h7FFF};
      3:       return {w[VAL_W-1:OPD_W], 16'h8000};
      default: return w[VAL_W-1:0];
    endcase
  endfunction

  // one transfer on the element channel, prediction at the accepting edge
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value,
                           input bit typed, input acc_t want);
    int gap;
    int n0;
    gap = tx_steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.row     <= row;
    in_ch.col     <= col;
    in_ch.value   <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n0 = expected_elems.size();
    predict_transfer(cmd, row, col, value);
    if (typed) begin
      for (int i = n0; i < expected_elems.size(); i++) begin
        expected_elems[i].value = want;
      end
    end
    items_in++;
  endtask

  // a compute first gets every operand it reads loaded
  task automatic issue_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value,
                            input bit typed, input acc_t want);
    int kd;
    if (cmd == CMD_COMPUTE && !block_empty()) begin
      kd = eff_terms();
      for (int r = block_cfg.row_first; r <= int'(block_cfg.row_last); r++) begin
        for (int k = 0; k < kd; k++) begin
          if (!a_loaded[r*DIM+k]) begin
            send_item(CMD_WRITE_A, IDX_W'(r), IDX_W'(k), draw_value(), 1'b0, '0);
          end
        end
      end
      for (int k = 0; k < kd; k++) begin
        for (int c = block_cfg.col_first; c <= int'(block_cfg.col_last); c++) begin
          if (!b_loaded[k*DIM+c]) begin
            send_item(CMD_WRITE_B, IDX_W'(k), IDX_W'(c), draw_value(), 1'b0, '0);
          end
        end
      end
    end
    send_item(cmd, row, col, value, typed, want);
  endtask

  // hold off the sender until every expected element has arrived
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_COMMON_DIM: block_cfg.common_dim = data;
      CFG_ROW_FIRST:  block_cfg.row_first  = data[IDX_W-1:0];
      CFG_ROW_LAST:   block_cfg.row_last   = data[IDX_W-1:0];
      CFG_COL_FIRST:  block_cfg.col_first  = data[IDX_W-1:0];
      CFG_COL_LAST:   block_cfg.col_last   = data[IDX_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // new block shape: mostly small, now and then the whole matrix or an empty one
  task automatic program_block();
    int r0;
    int r1;
    int c0;
    int c1;
    int kd;
    case ($urandom_range(0, 9))
      0: begin
        r0 = 0; r1 = DIM - 1; c0 = 0; c1 = DIM - 1;
      end
      1: begin
        r0 = $urandom_range(1, DIM - 1);
        r1 = $urandom_range(0, r0 - 1);
        c0 = $urandom_range(0, DIM - 1);
        c1 = $urandom_range(c0, DIM - 1);
      end
      default: begin
        r0 = $urandom_range(0, DIM - 1);
        r1 = r0 + $urandom_range(0, 2);
        c0 = $urandom_range(0, DIM - 1);
        c1 = c0 + $urandom_range(0, 2);
        if (r1 > DIM - 1) r1 = DIM - 1;
        if (c1 > DIM - 1) c1 = DIM - 1;
      end
    endcase
    kd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, DIM);
    write_reg(CFG_COMMON_DIM, CFG_DATA_W'(kd));
    write_reg(CFG_ROW_FIRST, {1'($urandom_range(0, 1)), IDX_W'(r0)});
    write_reg(CFG_ROW_LAST,  {1'($urandom_range(0, 1)), IDX_W'(r1)});
    write_reg(CFG_COL_FIRST, {1'($urandom_range(0, 1)), IDX_W'(c0)});
    write_reg(CFG_COL_LAST,  {1'($urandom_range(0, 1)), IDX_W'(c1)});
    if ($urandom_range(0, 7) == 0) begin
      write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 15)));
    end
  endtask

  // compare one result transfer with the oldest expectation
  task automatic check_result();
    elem_t e;
    results_seen++;
    if (expected_elems.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d col %0d value %0h",
                                out_ch.out_row, out_ch.out_col, out_ch.out_value));
      return;
    end
    e = expected_elems.pop_front();
    if (out_ch.out_row !== e.row) begin
      report_mismatch($sformatf("row %0d, expected %0d", out_ch.out_row, e.row));
    end
    if (out_ch.out_col !== e.col) begin
      report_mismatch($sformatf("col %0d, expected %0d", out_ch.out_col, e.col));
    end
    if (out_ch.out_value !== e.value) begin
      report_mismatch($sformatf("value %0h at (%0d,%0d), expected %0h",
                                out_ch.out_value, e.row, e.col, e.value));
    end
    if (out_ch.last !== e.last) begin
      report_mismatch($sformatf("last %0b at (%0d,%0d), expected %0b",
                                out_ch.last, e.row, e.col, e.last));
    end
  endtask

  // result side: random stall after each transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_hold = 0;
    end else if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      check_result();
      rx_hold = rx_steady ? 0 : $urandom_range(0, 8);
      out_ch.ready <= (rx_hold == 0);
    end else if (out_ch.ready !== 1'b1) begin
      if (rx_hold <= 1) begin
        out_ch.ready <= 1'b1;
      end
      rx_hold = rx_hold - 1;
    end
  end

  initial begin
    plan_row_t pr;
    bit        busy;
    bit        first;
    int        ops;
    int        pick;
    logic [CMD_W-1:0] wcmd;

    in_ch.valid   = 1'b0;
    in_ch.command = CMD_WRITE_A;
    in_ch.row     = '0;
    in_ch.col     = '0;
    in_ch.value   = '0;
    busy  = 1'b0;
    first = 1'b1;

    // reset state of the shadow copy
    for (int i = 0; i < DIM*DIM; i++) begin
      mat_a[i]    = '0;
      mat_b[i]    = '0;
      mat_c[i]    = '0;
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    block_cfg.common_dim = RST_COMMON_DIM;
    block_cfg.row_first  = RST_ROW_FIRST;
    block_cfg.row_last   = RST_ROW_LAST;
    block_cfg.col_first  = RST_COL_FIRST;
    block_cfg.col_last   = RST_COL_LAST;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // let the accumulator clearing pass finish before touching registers
    repeat (DIM*DIM + IDLE_CYCLES) @(posedge clk);

    // directed steps
    for (int i = 0; i < PLAN_LEN; i++) begin
      pr = PLAN[i];
      if (pr.kind == ROW_REG) begin
        if (busy) begin
          wait_drain();
          busy = 1'b0;
        end
        write_reg(pr.code, pr.value[CFG_DATA_W-1:0]);
      end else begin
        issue_item(pr.code[CMD_W-1:0], pr.row, pr.col, pr.value, pr.typed, pr.want);
        busy = 1'b1;
      end
    end
    directed_items = items_in;

    // random phases: new block shape, then writes and computes with random content
    while (items_in < ITEM_TARGET) begin
      wait_drain();
      program_block();
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      ops = $urandom_range(2, 10);
      for (int i = 0; i < ops && items_in < ITEM_TARGET; i++) begin
        pick = $urandom_range(0, 9);
        if (first && i == 0) pick = 6;
        if (pick == 9 || (first && i == 1)) begin
          wait_drain();
        end else if (pick >= 6) begin
          issue_item(CMD_COMPUTE, IDX_W'($urandom_range(0, 7)),
                     IDX_W'($urandom_range(0, 7)), draw_value(), 1'b0, '0);
        end else begin
          wcmd = (pick < 2) ? CMD_WRITE_A : (pick < 4) ? CMD_WRITE_B : CMD_WRITE_C;
          issue_item(wcmd, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                     draw_value(), 1'b0, '0);
        end
      end
      first = 1'b0;
    end

    wait_drain();
    $display("tb_top: %0d element transfers (%0d directed), %0d computes (%0d empty)",
             items_in, directed_items, computes, empty_computes);
    $display("tb_top: %0d reg writes, %0d results checked, %0d saturated, %0d mismatches",
             reg_writes, results_seen, saturated, errors);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

FILE: block_matrix_multiply_accumulate.f
+incdir+sv
sv/bmma_pkg.sv
sv/bmma_if.sv
sv/bmma_opmem.sv
sv/bmma_accmem.sv
sv/bmma_mac.sv
sv/bmma_ctrl.sv
sv/block_matrix_multiply_accumulate.sv
sv/bmma_chk.sv
tb/tb_top.sv
